@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, controller state, command and status structs.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_REDUCE  = 2'd0,
        OP_ADD     = 2'd1,
        OP_MUL     = 2'd2,
        OP_COMPARE = 2'd3
    } op_t;

    // multiplier operand selection
    localparam logic [1:0] MSEL_AB = 2'd0;  // a_num * b_den (a_num * b_num for multiply)
    localparam logic [1:0] MSEL_BA = 2'd1;  // b_num * a_den
    localparam logic [1:0] MSEL_DD = 2'd2;  // a_den * b_den

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic mul_step;  // one multiply/cross-product step
        logic [1:0] mul_sel;
        logic prep;      // form magnitude and denominator, start gcd
        logic gcd_step;  // one remainder step
        logic div_start; // start serial divide
        logic div_den;   // 0: numerator quotient, 1: denominator quotient
        logic finish;    // build result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_compare;
        logic den_zero;  // denominator to reduce is zero
        logic gcd_done;
        logic div_busy;
    } status_t;

endpackage

@@ rtl/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing of one request
// Steps multiply, gcd and divide phases and the output handshake.
// ----------------------------------------------------------------------------
module rau_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_fire,
    input  rau_pkg::status_t status,
    output rau_pkg::cmd_t    cmd,
    output logic             idle,
    output logic             out_valid
);

    rau_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rau_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = rau_pkg::ST_MUL1;
                end
            end
            rau_pkg::ST_MUL1:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = rau_pkg::MSEL_AB;
                state_next   = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = rau_pkg::MSEL_BA;
                state_next   = rau_pkg::ST_MUL3;
            end
            rau_pkg::ST_MUL3:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = rau_pkg::MSEL_DD;
                state_next   = rau_pkg::ST_PREP;
            end
            rau_pkg::ST_PREP:
            begin
                if (status.is_compare)
                begin
                    cmd.finish = 1'b1;
                    state_next = rau_pkg::ST_OUT;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD:
            begin
                if (status.den_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = rau_pkg::ST_OUT;
                end
                else if (status.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rau_pkg::ST_DIVN;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            rau_pkg::ST_DIVN:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_den   = 1'b1;
                    state_next    = rau_pkg::ST_DIVD;
                end
            end
            rau_pkg::ST_DIVD:
            begin
                cmd.div_den = 1'b1;
                if (!status.div_busy)
                    state_next = rau_pkg::ST_DIV_WAIT;
            end
            rau_pkg::ST_DIV_WAIT:
            begin
                cmd.finish = 1'b1;
                state_next = rau_pkg::ST_OUT;
            end
            rau_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = rau_pkg::ST_IDLE;
            end
            default:
                state_next = rau_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ rtl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// rau_datapath: products, Euclid remainder unit and serial divider
// A single bit-serial divider does the gcd remainders and both quotients.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rau_pkg::cmd_t        cmd,
    output rau_pkg::status_t     status,
    input  logic [1:0]           req_type,
    input  logic [31:0]          a_num,
    input  logic [31:0]          a_den,
    input  logic [31:0]          b_num,
    input  logic [31:0]          b_den,
    output logic [31:0]          res_num,
    output logic [31:0]          res_den,
    output logic [1:0]           order,
    output logic                 den_zero_error
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    // captured item
    logic [1:0]     op_reg;
    logic [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    // products
    logic [2*W-1:0] p0_reg, p1_reg, p2_reg;
    logic [2*W-1:0] mul_res;
    logic signed [W:0]   mx, my;
    logic signed [2*W+1:0] mprod;
    // fraction under reduction
    logic [W-1:0]   num_reg, den_reg, mag_reg;
    logic           neg_reg;
    logic [W-1:0]   gx_reg, gy_reg;
    // serial divider
    logic           dbusy_reg;
    logic [CW-1:0]  dcnt_reg;
    logic [W-1:0]   dq_reg, dr_reg, dd_reg;
    logic [W:0]     dtrial;
    logic           dgcd_reg;
    logic [W-1:0]   qn_reg;
    // result
    logic [31:0]    rn_reg, rd_reg;
    logic [1:0]     ord_reg;
    logic           err_reg;

    logic [W-1:0]   sum_num, den_prod, num_sel, num_mag, qn_signed;
    logic signed [2*W+1:0] lft, rgt;

    // multiplier operand selection: signed for compare, else modulo products
    always_comb
    begin
        mx = '0;
        my = '0;
        case (cmd.mul_sel)
            rau_pkg::MSEL_AB:
            begin
                mx = {an_reg[W-1] & (op_reg == rau_pkg::OP_COMPARE), an_reg};
                my = {1'b0, (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg};
                if (op_reg == rau_pkg::OP_MUL)
                    my = {1'b0, bn_reg};
            end
            rau_pkg::MSEL_BA:
            begin
                mx = {bn_reg[W-1] & (op_reg == rau_pkg::OP_COMPARE), bn_reg};
                my = {1'b0, ad_reg};
            end
            default:
            begin
                mx = {1'b0, ad_reg};
                my = {1'b0, bd_reg};
            end
        endcase
        mprod   = mx * my;
        mul_res = mprod[2*W-1:0];
    end

    assign sum_num  = p0_reg[W-1:0] + p1_reg[W-1:0];
    assign den_prod = p2_reg[W-1:0];
    assign lft      = {{2{p0_reg[2*W-1]}}, p0_reg};
    assign rgt      = {{2{p1_reg[2*W-1]}}, p1_reg};

    always_comb
    begin
        case (op_reg)
            rau_pkg::OP_ADD: num_sel = sum_num;
            rau_pkg::OP_MUL: num_sel = p0_reg[W-1:0];
            default:         num_sel = an_reg;
        endcase
    end
    assign num_mag   = num_sel[W-1] ? (~num_sel + 1'b1) : num_sel;
    assign dtrial    = {dr_reg, dd_reg[W-1]} - {1'b0, (dgcd_reg ? gy_reg : gx_reg)};
    assign qn_signed = neg_reg ? (~qn_reg + 1'b1) : qn_reg;

    assign status.is_compare = (op_reg == rau_pkg::OP_COMPARE);
    assign status.den_zero   = (den_reg == '0);
    assign status.gcd_done   = (gy_reg == '0) && !dbusy_reg;
    assign status.div_busy   = dbusy_reg;

    // control state of the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if ((cmd.gcd_step && !dbusy_reg) || cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= CW'(W);
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == CW'(1))
                dbusy_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req_type;
            an_reg <= a_num[W-1:0];
            ad_reg <= a_den[W-1:0];
            bn_reg <= b_num[W-1:0];
            bd_reg <= b_den[W-1:0];
        end
        if (cmd.mul_step)
        begin
            case (cmd.mul_sel)
                rau_pkg::MSEL_AB: p0_reg <= mul_res;
                rau_pkg::MSEL_BA: p1_reg <= mul_res;
                default:          p2_reg <= mul_res;
            endcase
        end
        if (cmd.prep)
        begin
            num_reg <= num_sel;
            den_reg <= (op_reg == rau_pkg::OP_REDUCE) ? ad_reg : den_prod;
            mag_reg <= num_mag;
            neg_reg <= num_sel[W-1];
            gx_reg  <= num_mag;
            gy_reg  <= (op_reg == rau_pkg::OP_REDUCE) ? ad_reg : den_prod;
        end
        // gcd step: start remainder x mod y (divisor y)
        if (cmd.gcd_step && !dbusy_reg)
        begin
            dgcd_reg <= 1'b1;
            dd_reg   <= gx_reg;
            dr_reg   <= '0;
        end
        // quotient: divide by gcd, which sits in gx
        if (cmd.div_start)
        begin
            dgcd_reg <= 1'b0;
            dd_reg   <= cmd.div_den ? den_reg : mag_reg;
            dr_reg   <= '0;
            if (cmd.div_den)
                qn_reg <= dq_reg;
        end
        // restoring division, one quotient bit a cycle
        if (dbusy_reg)
        begin
            if (!dtrial[W])
            begin
                dr_reg <= dtrial[W-1:0];
                dq_reg <= {dq_reg[W-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[W-2:0], dd_reg[W-1]};
                dq_reg <= {dq_reg[W-2:0], 1'b0};
            end
            dd_reg <= {dd_reg[W-2:0], 1'b0};
            if (dcnt_reg == CW'(1) && dgcd_reg)
            begin
                gx_reg <= gy_reg;
                gy_reg <= dtrial[W] ? {dr_reg[W-2:0], dd_reg[W-1]} : dtrial[W-1:0];
            end
        end
        if (cmd.finish)
        begin
            if (op_reg == rau_pkg::OP_COMPARE)
            begin
                rn_reg  <= '0;
                rd_reg  <= '0;
                err_reg <= 1'b0;
                ord_reg <= ($signed(lft) < $signed(rgt)) ? 2'b11 :
                           (($signed(lft) > $signed(rgt)) ? 2'b01 : 2'b00);
            end
            else if (den_reg == '0)
            begin
                rn_reg  <= 32'($signed(num_reg));
                rd_reg  <= '0;
                err_reg <= 1'b1;
                ord_reg <= '0;
            end
            else
            begin
                rn_reg  <= 32'($signed(qn_signed));
                rd_reg  <= 32'(dq_reg);
                err_reg <= 1'b0;
                ord_reg <= '0;
            end
        end
    end

    assign res_num        = rn_reg;
    assign res_den        = rd_reg;
    assign order          = ord_reg;
    assign den_zero_error = err_reg;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: reduce, add, multiply and compare fractions
// Euclidean gcd reduction on a shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit first)                     | tuser
//  s_axis    | in  | a_num, a_den, b_num, b_den (128 bits)     | req_type
//  m_axis    | out | res_num, res_den, order, den_zero_error   | -
//
// One item at a time: for compare the result follows the three products;
// a zero denominator ends the request at the gcd state; otherwise every
// Euclid remainder step and each of the two quotients is one full pass
// of the one restoring divider.
// Reset clears the controller and the divider control only. s_axis_tready
// is high only when idle; the result holds on m_axis until taken.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // res_num, res_den, order, den_zero_error, pad
);

    rau_pkg::cmd_t    cmd;
    rau_pkg::status_t status;
    logic             idle;
    logic [31:0]      res_num, res_den;
    logic [1:0]       order;
    logic             den_zero_error;

    assign s_axis_tready = idle;

    rau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid & idle),
        .out_fire  (m_axis_tready),
        .status    (status),
        .cmd       (cmd),
        .idle      (idle),
        .out_valid (m_axis_tvalid)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_type       (s_axis_tuser),
        .a_num          (s_axis_tdata[31:0]),
        .a_den          (s_axis_tdata[63:32]),
        .b_num          (s_axis_tdata[95:64]),
        .b_den          (s_axis_tdata[127:96]),
        .res_num        (res_num),
        .res_den        (res_den),
        .order          (order),
        .den_zero_error (den_zero_error)
    );

    assign m_axis_tdata = {5'd0, den_zero_error, order, res_den, res_num};

endmodule

@@ rtl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// Bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata
);

    // one item in flight: no input taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // order never reads as the unused code
    a_ord: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[65:64] != 2'b10) else $error("bad order code");

    // accepted item cannot produce a result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("result too early");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
